>>> hdl/iba_pkg.sv
// ----------------------------------------------------------------------------
// iba_pkg
// types, constants and codes shared by the block allocator
// ----------------------------------------------------------------------------
package iba_pkg;

   localparam int NUM_BLOCKS      = 64;
   localparam int NUM_INODES      = 8;
   localparam int BLOCKS_PER_FILE = 8;
   localparam int NAME_BYTES      = 20;

   localparam int BLK_W   = $clog2(NUM_BLOCKS);
   localparam int INO_W   = $clog2(NUM_INODES);
   localparam int POS_W   = $clog2(BLOCKS_PER_FILE);
   localparam int CNT_W   = $clog2(BLOCKS_PER_FILE + 1);
   localparam int LIST_AW = INO_W + POS_W;
   localparam int LIST_D  = NUM_INODES * BLOCKS_PER_FILE;

   localparam logic [63:0] MASK_LOW  = (NAME_BYTES >= 8) ? {64{1'b1}} :
                                       ((64'd1 << (8 * NAME_BYTES)) - 64'd1);
   localparam logic [63:0] MASK_MID  = (NAME_BYTES >= 16) ? {64{1'b1}} :
                                       (NAME_BYTES <= 8) ? 64'd0 :
                                       ((64'd1 << (8 * (NAME_BYTES - 8))) - 64'd1);
   localparam logic [31:0] MASK_HIGH = (NAME_BYTES >= 20) ? {32{1'b1}} :
                                       (NAME_BYTES <= 16) ? 32'd0 :
                                       32'((64'd1 << (8 * (NAME_BYTES - 16))) - 64'd1);

   typedef enum logic [1:0] {
      ACT_CREATE = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_ADD    = 2'd2,
      ACT_REMOVE = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_INODE  = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FILE_FULL = 3'd3,
      ST_DISK_FULL = 3'd4,
      ST_NO_BLOCKS = 3'd5
   } status_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] name_bytes_low;
      logic [63:0] name_bytes_mid;
      logic [31:0] name_bytes_high;
      logic [3:0]  blocks_wanted;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [2:0] inode_slot;
      logic [5:0] block_number;
      logic [3:0] blocks_in_file;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOOKUP,
      S_DISPATCH,
      S_ALLOC,
      S_FREE_RD,
      S_FREE_WAIT,
      S_FREE_CLR,
      S_REM_RD,
      S_REM_WAIT,
      S_REM_CLR,
      S_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       lookup;
      logic       claim_inode;
      logic       take_match;
      logic       alloc_block;
      logic       list_rd;
      logic       free_block;
      logic       release_inode;
      logic       set_status;
      status_type status;
      logic       rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      action_type action;
      logic       found;
      logic       free_inode;
      logic       free_block;
      logic       alloc_done;
      logic       walk_done;
      logic       file_full;
      logic       file_empty;
   } sts_type;

endpackage

>>> hdl/iba_ram.sv
// ----------------------------------------------------------------------------
// iba_ram
// generic ram with one write port, one read port and registered read
// ----------------------------------------------------------------------------
module iba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> hdl/iba_datapath.sv
// ----------------------------------------------------------------------------
// iba_datapath
// free map, inode table, name match, block list and result register
// ----------------------------------------------------------------------------
module iba_datapath (
   input  logic             clock,
   input  logic             reset,
   input  iba_pkg::req_type req_in,
   input  iba_pkg::cmd_type cmd,
   output iba_pkg::sts_type sts,
   output iba_pkg::rsp_type rsp_data
);
   import iba_pkg::*;

   logic [63:0]       name_low_ff;
   logic [63:0]       name_mid_ff;
   logic [31:0]       name_high_ff;
   action_type        action_ff;
   logic [CNT_W-1:0]  wanted_ff;

   logic [NUM_BLOCKS-1:0] taken_ff;
   logic [NUM_INODES-1:0] used_ff;
   logic [CNT_W-1:0]      count_ff [NUM_INODES];
   logic [63:0]           sname_low_ff  [NUM_INODES];
   logic [63:0]           sname_mid_ff  [NUM_INODES];
   logic [31:0]           sname_high_ff [NUM_INODES];

   logic [NUM_INODES-1:0] match_ff;
   logic [INO_W-1:0]      slot_ff;
   logic                  found_ff;
   logic [CNT_W-1:0]      walk_ff;
   logic [BLK_W-1:0]      last_blk_ff;
   status_type            status_ff;
   rsp_type               rsp_ff;

   logic [INO_W-1:0] hit_idx;
   logic             hit_any;
   logic [INO_W-1:0] free_idx;
   logic             free_any;
   logic [BLK_W-1:0] fblk_idx;
   logic             fblk_any;
   logic [CNT_W-1:0] cur_cnt;
   logic [CNT_W-1:0] last_pos;

   logic                list_we;
   logic [LIST_AW-1:0]  list_wa;
   logic [LIST_AW-1:0]  list_ra;
   logic [BLK_W-1:0]    list_rd;

   always_comb begin
      hit_idx  = '0;
      hit_any  = 1'b0;
      free_idx = '0;
      free_any = 1'b0;
      for (int i = NUM_INODES - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_idx = INO_W'(i);
            hit_any = 1'b1;
         end
         if (!used_ff[i]) begin
            free_idx = INO_W'(i);
            free_any = 1'b1;
         end
      end
   end

   always_comb begin
      fblk_idx = '0;
      fblk_any = 1'b0;
      for (int b = NUM_BLOCKS - 1; b >= 0; b--) begin
         if (!taken_ff[b]) begin
            fblk_idx = BLK_W'(b);
            fblk_any = 1'b1;
         end
      end
   end

   assign cur_cnt  = count_ff[slot_ff];
   assign last_pos = cur_cnt - CNT_W'(1);

   assign list_we = cmd.alloc_block;
   assign list_wa = {slot_ff, cur_cnt[POS_W-1:0]};
   assign list_ra = (action_ff == ACT_REMOVE) ? {slot_ff, last_pos[POS_W-1:0]} :
                                                {slot_ff, walk_ff[POS_W-1:0]};

   iba_ram #(.WIDTH(BLK_W), .DEPTH(LIST_D)) u_list (
      .clock   (clock),
      .wr_en   (list_we),
      .wr_addr (list_wa),
      .wr_data (fblk_idx),
      .rd_addr (list_ra),
      .rd_data (list_rd)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         action_ff    <= action_type'(req_in.action);
         name_low_ff  <= req_in.name_bytes_low & MASK_LOW;
         name_mid_ff  <= req_in.name_bytes_mid & MASK_MID;
         name_high_ff <= req_in.name_bytes_high & MASK_HIGH;
         wanted_ff    <= (req_in.blocks_wanted > 4'(BLOCKS_PER_FILE)) ?
                         CNT_W'(BLOCKS_PER_FILE) : CNT_W'(req_in.blocks_wanted);
      end
      if (cmd.lookup) begin
         for (int i = 0; i < NUM_INODES; i++) begin
            match_ff[i] <= used_ff[i] && sname_low_ff[i] == name_low_ff &&
                           sname_mid_ff[i] == name_mid_ff &&
                           sname_high_ff[i] == name_high_ff;
         end
         walk_ff     <= '0;
         last_blk_ff <= '0;
         status_ff   <= ST_OK;
         found_ff    <= 1'b0;
      end
      if (cmd.claim_inode) begin
         slot_ff <= free_idx;
         found_ff <= 1'b1;
         sname_low_ff[free_idx]  <= name_low_ff;
         sname_mid_ff[free_idx]  <= name_mid_ff;
         sname_high_ff[free_idx] <= name_high_ff;
      end
      if (cmd.take_match) begin
         slot_ff  <= hit_idx;
         found_ff <= hit_any;
      end
      if (cmd.alloc_block) begin
         last_blk_ff <= fblk_idx;
      end
      if (cmd.list_rd) begin
         walk_ff <= walk_ff + CNT_W'(1);
      end
      if (cmd.free_block && action_ff == ACT_REMOVE) begin
         last_blk_ff <= list_rd;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
      if (cmd.rsp_load) begin
         rsp_ff.status         <= status_ff;
         rsp_ff.inode_slot     <= found_ff ? 3'(slot_ff) : 3'd0;
         rsp_ff.block_number   <= found_ff ? 6'(last_blk_ff) : 6'd0;
         rsp_ff.blocks_in_file <= found_ff ? 4'(cur_cnt) : 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff <= '0;
         used_ff  <= '0;
         for (int i = 0; i < NUM_INODES; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         if (cmd.claim_inode) begin
            used_ff[free_idx]  <= 1'b1;
            count_ff[free_idx] <= '0;
         end
         if (cmd.alloc_block) begin
            taken_ff[fblk_idx] <= 1'b1;
            count_ff[slot_ff]  <= cur_cnt + CNT_W'(1);
         end
         if (cmd.free_block) begin
            taken_ff[list_rd] <= 1'b0;
            if (action_ff == ACT_REMOVE) begin
               count_ff[slot_ff] <= cur_cnt - CNT_W'(1);
            end
         end
         if (cmd.release_inode) begin
            used_ff[slot_ff]  <= 1'b0;
            count_ff[slot_ff] <= '0;
         end
      end
   end

   assign sts.action     = action_ff;
   assign sts.found      = hit_any;
   assign sts.free_inode = free_any;
   assign sts.free_block = fblk_any;
   assign sts.alloc_done = (cur_cnt >= wanted_ff);
   assign sts.walk_done  = (walk_ff >= cur_cnt);
   assign sts.file_full  = (cur_cnt >= CNT_W'(BLOCKS_PER_FILE));
   assign sts.file_empty = (cur_cnt == '0);
   assign rsp_data       = rsp_ff;

endmodule

>>> hdl/iba_controller.sv
// ----------------------------------------------------------------------------
// iba_controller
// sequences lookup, allocation and release steps for one transaction
// ----------------------------------------------------------------------------
module iba_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  iba_pkg::sts_type sts,
   output iba_pkg::cmd_type cmd
);
   import iba_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:      if (req_valid) state_in = S_LOOKUP;
         S_LOOKUP:    state_in = S_DISPATCH;
         S_DISPATCH: begin
            unique case (sts.action)
               ACT_CREATE: state_in = sts.free_inode ? S_ALLOC : S_RESP;
               ACT_DELETE: state_in = sts.found ? S_FREE_RD : S_RESP;
               ACT_ADD:    state_in = sts.found ? S_ALLOC : S_RESP;
               ACT_REMOVE: state_in = sts.found ? S_REM_RD : S_RESP;
               default:    state_in = S_RESP;
            endcase
         end
         S_ALLOC: begin
            if (sts.action == ACT_ADD || sts.alloc_done || !sts.free_block) begin
               state_in = S_RESP;
            end
         end
         S_FREE_RD:   state_in = sts.walk_done ? S_RESP : S_FREE_WAIT;
         S_FREE_WAIT: state_in = S_FREE_CLR;
         S_FREE_CLR:  state_in = S_FREE_RD;
         S_REM_RD:    state_in = sts.file_empty ? S_RESP : S_REM_WAIT;
         S_REM_WAIT:  state_in = S_REM_CLR;
         S_REM_CLR:   state_in = S_RESP;
         S_RESP:      if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.status = ST_OK;
      unique case (state_ff)
         S_IDLE:   cmd.load_req = req_valid;
         S_LOOKUP: cmd.lookup = 1'b1;
         S_DISPATCH: begin
            unique case (sts.action)
               ACT_CREATE: begin
                  cmd.claim_inode = sts.free_inode;
                  cmd.set_status  = !sts.free_inode;
                  cmd.status      = ST_NO_INODE;
               end
               default: begin
                  cmd.take_match = 1'b1;
                  cmd.set_status = !sts.found;
                  cmd.status     = ST_NOT_FOUND;
               end
            endcase
         end
         S_ALLOC: begin
            if (sts.action == ACT_ADD) begin
               cmd.alloc_block = !sts.file_full && sts.free_block;
               cmd.set_status  = sts.file_full || !sts.free_block;
               cmd.status      = sts.file_full ? ST_FILE_FULL : ST_DISK_FULL;
            end else if (!sts.alloc_done) begin
               cmd.alloc_block = sts.free_block;
               cmd.set_status  = !sts.free_block;
               cmd.status      = ST_DISK_FULL;
            end
         end
         S_FREE_RD:   cmd.release_inode = sts.walk_done;
         S_FREE_WAIT: cmd.list_rd = 1'b1;
         S_FREE_CLR:  cmd.free_block = 1'b1;
         S_REM_RD: begin
            cmd.set_status = sts.file_empty;
            cmd.status     = ST_NO_BLOCKS;
         end
         S_REM_WAIT:  cmd.list_rd = 1'b0;
         S_REM_CLR:   cmd.free_block = 1'b1;
         S_RESP:      cmd.rsp_load = !rsp_valid_ff || rsp_ready;
         default:     cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hdl/inode_block_allocator.sv
// ----------------------------------------------------------------------------
// inode_block_allocator
// free map block allocator with a small inode table
// ----------------------------------------------------------------------------
// usage:
//   req_ channel carries one transaction: action, a three word file name and
//   the block count wanted on create. rsp_ channel returns one result per
//   request: status, inode slot, block number and the file's block count.
//   both channels use valid/ready; a transaction moves when both are high.
// sequencing:
//   each request passes a lookup and a dispatch step; add then allocates at
//   most one block, create one per step until it has the count wanted or the
//   disk is full, delete reads, waits on and clears each of the file's blocks
//   before it frees the inode, remove does so for the last block only, and an
//   unknown file or a full inode table goes straight to the result step.
// reset:
//   synchronous reset frees all blocks and marks every inode unused; req_ready
//   is gated by reset and goes high as soon as reset is low.
// stall:
//   a result waits in the output register while rsp_ready is low; the next
//   request is taken and processed, holding at its result step until the
//   register frees up.
// ----------------------------------------------------------------------------
module inode_block_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  iba_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output iba_pkg::rsp_type rsp_data
);
   import iba_pkg::*;

   cmd_type cmd;
   sts_type sts;

   iba_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   iba_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_in   (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= 3'd5)
      else $error("status out of range");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.blocks_in_file <= 4'(BLOCKS_PER_FILE))
      else $error("block count out of range");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.alloc_block, cmd.free_block, cmd.claim_inode, cmd.release_inode}))
      else $error("conflicting datapath commands");

   a_no_busy_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while busy");

endmodule
